// ----- hw/rtl/owtr_pkg.sv -----
// Shared types, register codes and reset values for the one-wire temperature reader.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package owtr_pkg;

   // Width of the widest configuration register (the conversion wait).
   localparam int DUR_W = 20;
   localparam int SLOT_W = 16;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [2:0] CSR_SLOT_START    = 3'd3;
   localparam logic [2:0] CSR_WRITE_SLOT    = 3'd4;
   localparam logic [2:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [2:0] CSR_READ_TAIL     = 3'd6;
   localparam logic [2:0] CSR_CONV_WAIT     = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [SLOT_W-1:0] RST_RESET_LOW     = 16'd480;
   localparam logic [SLOT_W-1:0] RST_PRESENCE_WAIT = 16'd70;
   localparam logic [SLOT_W-1:0] RST_RESET_TAIL    = 16'd410;
   localparam logic [SLOT_W-1:0] RST_SLOT_START    = 16'd2;
   localparam logic [SLOT_W-1:0] RST_WRITE_SLOT    = 16'd60;
   localparam logic [SLOT_W-1:0] RST_READ_SAMPLE   = 16'd15;
   localparam logic [SLOT_W-1:0] RST_READ_TAIL     = 16'd60;
   localparam logic [DUR_W-1:0]  RST_CONV_WAIT     = 20'd750;

   // Bus command bytes.
   localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0] CMD_CONVERT    = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   // Presence status codes.
   localparam logic [1:0] STAT_PRESENT  = 2'd0;
   localparam logic [1:0] STAT_ABSENT   = 2'd1;
   localparam logic [1:0] STAT_SHORTED  = 2'd2;

   typedef struct packed {
      logic [SLOT_W-1:0] reset_low_ticks;
      logic [SLOT_W-1:0] presence_wait_ticks;
      logic [SLOT_W-1:0] reset_tail_ticks;
      logic [SLOT_W-1:0] slot_start_ticks;
      logic [SLOT_W-1:0] write_slot_ticks;
      logic [SLOT_W-1:0] read_sample_ticks;
      logic [SLOT_W-1:0] read_tail_ticks;
      logic [DUR_W-1:0]  conversion_wait_ticks;
   } cfg_type;

   // Timer control from the sequencer: step advances on an accepted tick,
   // timed says the current phase runs against a duration.
   typedef struct packed {
      logic step;
      logic timed;
   } tmr_ctl_type;

   // One result word, drive_low in the lowest bit.
   typedef struct packed {
      logic [10:0] temperature_tenths;
      logic [1:0]  status;
      logic        done_res;
      logic        busy_res;
      logic        power_on;
      logic        drive_low;
   } rsp_word_type;

   // Raw sensor word to tenths of a degree: whole degrees times ten plus the
   // truncated tenths of the four fraction bits.
   function automatic logic [10:0] tenths_of(input logic [15:0] raw);
      logic [10:0] whole;
      logic [7:0]  frac;
      whole = 11'(raw[10:4]) * 11'd10;
      frac  = 8'(raw[3:0]) * 8'd10;
      return whole + 11'(frac[7:4]);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/one_wire_temperature_reader.sv -----
// Top level of the one-wire temperature reader: configuration registers,
// stream handshake and result register. Depends on owtr_pkg and owtr_sequencer.
//
//   channel   direction  words                       data
//   req_*     in         one per timebase tick       start_req, line_in
//   rsp_*     out        one per accepted req word   bus drive, power, busy, done,
//                                                    status, temperature
//   csr_*     in         register writes, no reply   tick counts per bus phase
//
// Each accepted request word yields exactly one response word in the next cycle.
// A new request word is taken in every cycle while the response register is empty
// or being drained, so the block sustains one tick per clock.
// Reset is synchronous and active high; it returns the sequencer to idle with
// default bus timing and clears the held status and temperature.
// When the response side stalls, the request side stalls with it and no tick is lost.
`default_nettype none

module one_wire_temperature_reader
   import owtr_pkg::*;
#(
   parameter int SCRATCH_BYTES = 9,
   parameter int TIMER_WIDTH   = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Request stream, one word per bus tick.
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,   // [0] start_req, [1] line_in, rest zero
   // Response stream.
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [23:0]           rsp_tdata,   // [0] drive_low, [1] power_on, [2] busy_res,
                                              // [3] done_res, [5:4] status,
                                              // [16:6] temperature_tenths, rest zero
   // Configuration write port.
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [DUR_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         req_accept;

   // The response register frees up in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   owtr_sequencer #(
      .SCRATCH_BYTES(SCRATCH_BYTES),
      .TIMER_WIDTH  (TIMER_WIDTH)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .step     (req_accept),
      .start_req(req_tdata[0]),
      .line_in  (req_tdata[1]),
      .cfg      (cfg_ff),
      .word     (rsp_word_in)
   );

   // Configuration writes; each register keeps only its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_ticks       = csr_wdata[SLOT_W-1:0];
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks   = csr_wdata[SLOT_W-1:0];
            CSR_RESET_TAIL:    cfg_in.reset_tail_ticks      = csr_wdata[SLOT_W-1:0];
            CSR_SLOT_START:    cfg_in.slot_start_ticks      = csr_wdata[SLOT_W-1:0];
            CSR_WRITE_SLOT:    cfg_in.write_slot_ticks      = csr_wdata[SLOT_W-1:0];
            CSR_READ_SAMPLE:   cfg_in.read_sample_ticks     = csr_wdata[SLOT_W-1:0];
            CSR_READ_TAIL:     cfg_in.read_tail_ticks       = csr_wdata[SLOT_W-1:0];
            CSR_CONV_WAIT:     cfg_in.conversion_wait_ticks = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= RST_RESET_LOW;
         cfg_ff.presence_wait_ticks   <= RST_PRESENCE_WAIT;
         cfg_ff.reset_tail_ticks      <= RST_RESET_TAIL;
         cfg_ff.slot_start_ticks      <= RST_SLOT_START;
         cfg_ff.write_slot_ticks      <= RST_WRITE_SLOT;
         cfg_ff.read_sample_ticks     <= RST_READ_SAMPLE;
         cfg_ff.read_tail_ticks       <= RST_READ_TAIL;
         cfg_ff.conversion_wait_ticks <= RST_CONV_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Response register: loaded on every accepted tick, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_word_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/owtr_tick_timer.sv -----
// Tick counter that times each bus phase against a configured duration.
// Depends on owtr_pkg for the control struct and duration width.
`default_nettype none

module owtr_tick_timer
   import owtr_pkg::*;
#(
   parameter int TIMER_WIDTH = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tmr_ctl_type      ctl,
   input  wire logic [DUR_W-1:0] dur,
   output logic                  elapsed
);

   localparam int CW = ((TIMER_WIDTH > DUR_W) ? TIMER_WIDTH : DUR_W) + 1;
   localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

   logic [TIMER_WIDTH-1:0] tick_ff, tick_in;
   logic [CW-1:0]          dur_ext, eff, count_next;

   always_comb begin
      dur_ext = CW'(dur);
      // A zero duration counts as one tick; long ones saturate at the timer range.
      eff = (dur_ext == '0) ? CW'(1) : dur_ext;
      if (eff > TMAX) begin
         eff = TMAX;
      end
      count_next = CW'(tick_ff) + CW'(1);
      elapsed = (count_next >= eff);
   end

   always_comb begin
      tick_in = tick_ff;
      if (ctl.step) begin
         if (!ctl.timed || elapsed) begin
            tick_in = '0;
         end else begin
            tick_in = TIMER_WIDTH'(count_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/owtr_sequencer.sv -----
// Phase sequencer of the one-wire read cycle: reset/presence, command bytes,
// conversion wait and scratchpad read. Depends on owtr_pkg and owtr_tick_timer.
`default_nettype none

module owtr_sequencer
   import owtr_pkg::*;
#(
   parameter int SCRATCH_BYTES = 9,
   parameter int TIMER_WIDTH   = 20
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire logic    start_req,
   input  wire logic    line_in,
   input  wire cfg_type cfg,
   output rsp_word_type word
);

   typedef enum logic [10:0] {
      PH_IDLE   = 11'b000_0000_0001,
      PH_CHECK  = 11'b000_0000_0010,
      PH_RLOW   = 11'b000_0000_0100,
      PH_RWAIT  = 11'b000_0000_1000,
      PH_RTAIL  = 11'b000_0001_0000,
      PH_WSTART = 11'b000_0010_0000,
      PH_WHOLD  = 11'b000_0100_0000,
      PH_CONV   = 11'b000_1000_0000,
      PH_DSTART = 11'b001_0000_0000,
      PH_DWAIT  = 11'b010_0000_0000,
      PH_DTAIL  = 11'b100_0000_0000
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic         round_ff, round_in;
   logic [2:0]   bit_ff, bit_in;
   logic [3:0]   byte_ff, byte_in;
   logic [7:0]   shift_ff, shift_in;
   logic [15:0]  raw_ff, raw_in;
   logic [1:0]   status_ff, status_in;
   logic [10:0]  temp_ff, temp_in;
   logic         presence_ff, presence_in;
   logic         done;
   logic         busy;
   logic [2:0]   bit_next;
   logic [3:0]   byte_next;
   logic         elapsed;
   logic [DUR_W-1:0] dur;
   tmr_ctl_type  tmr_ctl;

   owtr_tick_timer #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_timer (
      .clock  (clock),
      .reset  (reset),
      .ctl    (tmr_ctl),
      .dur    (dur),
      .elapsed(elapsed)
   );

   // Duration of the current phase.
   always_comb begin
      dur = '0;
      tmr_ctl.step  = step;
      tmr_ctl.timed = 1'b1;
      case (phase_ff)
         PH_RLOW:   dur = DUR_W'(cfg.reset_low_ticks);
         PH_RWAIT:  dur = DUR_W'(cfg.presence_wait_ticks);
         PH_RTAIL:  dur = DUR_W'(cfg.reset_tail_ticks);
         PH_WSTART: dur = DUR_W'(cfg.slot_start_ticks);
         PH_DSTART: dur = DUR_W'(cfg.slot_start_ticks);
         PH_WHOLD:  dur = DUR_W'(cfg.write_slot_ticks);
         PH_DWAIT:  dur = DUR_W'(cfg.read_sample_ticks);
         PH_DTAIL:  dur = DUR_W'(cfg.read_tail_ticks);
         PH_CONV:   dur = cfg.conversion_wait_ticks;
         default:   tmr_ctl.timed = 1'b0;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      round_in    = round_ff;
      bit_in      = bit_ff;
      byte_in     = byte_ff;
      shift_in    = shift_ff;
      raw_in      = raw_ff;
      status_in   = status_ff;
      temp_in     = temp_ff;
      presence_in = presence_ff;
      done        = 1'b0;
      bit_next    = bit_ff + 3'd1;
      byte_next   = byte_ff + 4'd1;
      case (phase_ff)
         PH_IDLE: begin
            round_in = 1'b0;
            if (start_req) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (!line_in) begin
               // Bus stuck low: skip the reset pulse and go on with commands.
               status_in = STAT_SHORTED;
               phase_in  = PH_WSTART;
               shift_in  = CMD_SKIP_ROM;
               bit_in    = '0;
               byte_in   = '0;
            end else begin
               phase_in = PH_RLOW;
            end
         end
         PH_RLOW: begin
            if (elapsed) begin
               phase_in = PH_RWAIT;
            end
         end
         PH_RWAIT: begin
            if (elapsed) begin
               presence_in = line_in;
               phase_in    = PH_RTAIL;
            end
         end
         PH_RTAIL: begin
            if (elapsed) begin
               status_in = presence_ff ? STAT_ABSENT : STAT_PRESENT;
               phase_in  = PH_WSTART;
               shift_in  = CMD_SKIP_ROM;
               bit_in    = '0;
               byte_in   = '0;
            end
         end
         PH_WSTART: begin
            if (elapsed) begin
               phase_in = PH_WHOLD;
            end
         end
         PH_WHOLD: begin
            if (elapsed) begin
               shift_in = {1'b0, shift_ff[7:1]};
               bit_in   = bit_next;
               phase_in = PH_WSTART;
               if (bit_next == 3'd0) begin
                  if (byte_next >= 4'd2) begin
                     byte_in  = '0;
                     phase_in = round_ff ? PH_DSTART : PH_CONV;
                  end else begin
                     byte_in  = byte_next;
                     shift_in = round_ff ? CMD_READ_SCRATCH : CMD_CONVERT;
                  end
               end
            end
         end
         PH_CONV: begin
            if (elapsed) begin
               round_in = 1'b1;
               phase_in = PH_CHECK;
            end
         end
         PH_DSTART: begin
            if (elapsed) begin
               phase_in = PH_DWAIT;
            end
         end
         PH_DWAIT: begin
            if (elapsed) begin
               shift_in = {line_in, shift_ff[7:1]};
               phase_in = PH_DTAIL;
            end
         end
         PH_DTAIL: begin
            if (elapsed) begin
               bit_in   = bit_next;
               phase_in = PH_DSTART;
               if (bit_next == 3'd0) begin
                  // The first two scratchpad bytes form the raw word, low byte first.
                  if (byte_ff == 4'd0) begin
                     raw_in[7:0] = shift_ff;
                  end else if (byte_ff == 4'd1) begin
                     raw_in[15:8] = shift_ff;
                  end
                  byte_in = byte_next;
                  if (byte_next >= 4'(SCRATCH_BYTES)) begin
                     temp_in  = tenths_of(raw_in);
                     done     = 1'b1;
                     byte_in  = '0;
                     phase_in = PH_IDLE;
                     round_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            round_in = 1'b0;
         end
      endcase
   end

   assign busy = (phase_ff != PH_IDLE);

   always_comb begin
      word.drive_low = (phase_ff == PH_RLOW) || (phase_ff == PH_WSTART) ||
                       (phase_ff == PH_DSTART) || ((phase_ff == PH_WHOLD) && !shift_ff[0]);
      word.power_on           = busy;
      word.busy_res           = busy;
      word.done_res           = done;
      word.status             = status_in;
      word.temperature_tenths = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         round_ff    <= 1'b0;
         bit_ff      <= '0;
         byte_ff     <= '0;
         shift_ff    <= '0;
         raw_ff      <= '0;
         status_ff   <= STAT_PRESENT;
         temp_ff     <= '0;
         presence_ff <= 1'b1;
      end else if (step) begin
         phase_ff    <= phase_in;
         round_ff    <= round_in;
         bit_ff      <= bit_in;
         byte_ff     <= byte_in;
         shift_ff    <= shift_in;
         raw_ff      <= raw_in;
         status_ff   <= status_in;
         temp_ff     <= temp_in;
         presence_ff <= presence_in;
      end
   end

`ifndef SYNTHESIS
   // The second round never survives into idle.
   assert property (@(posedge clock) disable iff (reset)
      !(round_ff && (phase_ff == PH_IDLE)))
      else $error("second-round flag set while idle");

   // A finished read returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> (phase_ff == PH_IDLE))
      else $error("sequencer not idle after done");

   // The end of the conversion wait opens the second reset round.
   assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff == PH_CONV) && elapsed) |=> (round_ff && (phase_ff == PH_CHECK)))
      else $error("conversion wait did not start the read round");

   // A shorted-line status is only ever set by the line check.
   assert property (@(posedge clock) disable iff (reset)
      ((status_ff == STAT_SHORTED) && ($past(status_ff) != STAT_SHORTED))
         |-> $past(phase_ff == PH_CHECK))
      else $error("shorted status set outside the line check");
`endif

endmodule

`default_nettype wire

// ----- tb/one_wire_temperature_reader_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the one-wire temperature reader: bus ticks go in, and
// every response word is compared with a typed word or a cycle-true software copy
// of the bus master. Depends on owtr_pkg and the one_wire_temperature_reader RTL.

module one_wire_temperature_reader_test;
   import owtr_pkg::*;

   localparam int SCRATCH_BYTES = 9;

   // Sequencer steps of the software copy. The second round (after the
   // conversion wait) is held in a separate flag.
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_CHECK, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL,
      SEQ_WR_START, SEQ_WR_HOLD, SEQ_CONVERT, SEQ_RD_START, SEQ_RD_WAIT, SEQ_RD_TAIL
   } seq_step_type;

   // Bus timing programs used by the test phases.
   typedef enum logic [1:0] {
      TIMING_ONES, TIMING_ZEROS, TIMING_SHORT_RANDOM, TIMING_MAX
   } timing_mode_type;

   // One row of the opening ticks; want is only used when known is set.
   typedef struct packed {
      logic         start_req;
      logic         line_in;
      logic         known;
      rsp_word_type want;
   } tick_row_type;

   localparam logic [2:0] REG_ORDER [8] = '{
      CSR_RESET_LOW, CSR_PRESENCE_WAIT, CSR_RESET_TAIL, CSR_SLOT_START,
      CSR_WRITE_SLOT, CSR_READ_SAMPLE, CSR_READ_TAIL, CSR_CONV_WAIT
   };

   localparam rsp_word_type IDLE_WORD = '0;
   // The first tick after start is the released line check; a low bus there
   // is a short, so the status jumps straight to shorted.
   localparam rsp_word_type SHORTED_CHECK_WORD = '{
      temperature_tenths: 11'd0, status: STAT_SHORTED, done_res: 1'b0,
      busy_res: 1'b1, power_on: 1'b1, drive_low: 1'b0
   };

   // Opening ticks at reset timing: idle ticks with both line levels, a start,
   // a shorted line check, and then busy ticks, some with a start request, which
   // the block must ignore.
   localparam tick_row_type OPENING_TICKS [12] = '{
      '{1'b0, 1'b1, 1'b1, IDLE_WORD},
      '{1'b0, 1'b0, 1'b1, IDLE_WORD},
      '{1'b1, 1'b1, 1'b1, IDLE_WORD},
      '{1'b1, 1'b0, 1'b1, SHORTED_CHECK_WORD},
      '{1'b1, 1'b1, 1'b0, IDLE_WORD},
      '{1'b1, 1'b0, 1'b0, IDLE_WORD},
      '{1'b0, 1'b1, 1'b0, IDLE_WORD},
      '{1'b1, 1'b1, 1'b0, IDLE_WORD},
      '{1'b0, 1'b0, 1'b0, IDLE_WORD},
      '{1'b1, 1'b1, 1'b0, IDLE_WORD},
      '{1'b1, 1'b0, 1'b0, IDLE_WORD},
      '{1'b0, 1'b1, 1'b0, IDLE_WORD}
   };

   // Clock, reset and every input of the block start at known values.
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // [0] start_req, [1] line_in, rest zero
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [23:0]      rsp_tdata;        // [0] drive_low, [1] power_on, [2] busy_res,
                                       // [3] done_res, [5:4] status,
                                       // [16:6] temperature_tenths, rest zero
   logic             csr_we = 1'b0;
   logic [2:0]       csr_index = CSR_RESET_LOW;
   logic [DUR_W-1:0] csr_wdata = '0;

   // Set during phases that run with no idling on either side.
   logic             no_idling = 1'b0;
   logic [5:0]       stall_left = '0;
   int               mismatch_count = 0;

   // Response words the block still owes, oldest first.
   rsp_word_type     predicted_words [$];

   // State of the software copy of the bus master.
   logic [DUR_W-1:0] bus_timing [8];
   seq_step_type     seq_step;
   logic             second_round;
   logic [19:0]      tick_cnt;
   logic [2:0]       bit_cnt;
   logic [3:0]       byte_cnt;
   logic [7:0]       shift_reg;
   logic [15:0]      raw_temp;
   logic [1:0]       status_q;
   logic [10:0]      tenths_q;
   logic             presence_q;

   one_wire_temperature_reader DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The slowest correct run is about 1900 ticks, each waiting out at most the
   // longest sender gap and the longest receiver stall. The limit sits about ten
   // times above the time such a run takes.
   initial begin
      #25_000_000;
      $display("one_wire_temperature_reader_test NOT OK");
      $finish;
   end

   // Idle length: mostly short, now and then a long pause.
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
   endfunction

   // ---------------------------------------------------------------------
   // Software copy of the bus master
   // ---------------------------------------------------------------------

   function automatic void reset_bus_master();
      bus_timing[CSR_RESET_LOW]     = DUR_W'(RST_RESET_LOW);
      bus_timing[CSR_PRESENCE_WAIT] = DUR_W'(RST_PRESENCE_WAIT);
      bus_timing[CSR_RESET_TAIL]    = DUR_W'(RST_RESET_TAIL);
      bus_timing[CSR_SLOT_START]    = DUR_W'(RST_SLOT_START);
      bus_timing[CSR_WRITE_SLOT]    = DUR_W'(RST_WRITE_SLOT);
      bus_timing[CSR_READ_SAMPLE]   = DUR_W'(RST_READ_SAMPLE);
      bus_timing[CSR_READ_TAIL]     = DUR_W'(RST_READ_TAIL);
      bus_timing[CSR_CONV_WAIT]     = RST_CONV_WAIT;
      seq_step     = SEQ_IDLE;
      second_round = 1'b0;
      tick_cnt     = '0;
      bit_cnt      = '0;
      byte_cnt     = '0;
      shift_reg    = '0;
      raw_temp     = '0;
      status_q     = STAT_PRESENT;
      tenths_q     = '0;
      presence_q   = 1'b1;
   endfunction

   // Counts one tick of the current step. A duration of zero behaves as one
   // tick; the last tick of the duration clears the counter and reports true.
   function automatic bit duration_over(input logic [DUR_W-1:0] dur);
      logic [DUR_W:0] limit;
      limit = (dur == '0) ? (DUR_W+1)'(1) : {1'b0, dur};
      if ({1'b0, tick_cnt} + (DUR_W+1)'(1) >= limit) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 20'd1;
      return 1'b0;
   endfunction

   // Every reset sequence ends by sending skip-ROM first.
   function automatic void open_commands();
      seq_step  = SEQ_WR_START;
      shift_reg = CMD_SKIP_ROM;
      bit_cnt   = '0;
      byte_cnt  = '0;
      tick_cnt  = '0;
   endfunction

   // Advances the copy by one tick and returns the response word it causes.
   // Drive, power and busy come from the step held before the tick; status
   // and temperature are the values after it.
   function automatic rsp_word_type step_bus_master(input logic start_req, input logic line_in);
      rsp_word_type word;
      logic [10:0]  degrees;
      logic [7:0]   fraction;
      word = '0;
      word.busy_res = (seq_step != SEQ_IDLE);
      word.power_on = word.busy_res;
      case (seq_step)
         SEQ_RST_LOW, SEQ_WR_START, SEQ_RD_START: word.drive_low = 1'b1;
         SEQ_WR_HOLD: word.drive_low = ~shift_reg[0];
         default: word.drive_low = 1'b0;
      endcase

      case (seq_step)
         SEQ_IDLE: begin
            second_round = 1'b0;
            if (start_req) begin
               seq_step = SEQ_CHECK;
               tick_cnt = '0;
            end
         end
         SEQ_CHECK: begin
            tick_cnt = '0;
            if (!line_in) begin
               status_q = STAT_SHORTED;
               open_commands();
            end else begin
               seq_step = SEQ_RST_LOW;
            end
         end
         SEQ_RST_LOW: begin
            if (duration_over(bus_timing[CSR_RESET_LOW])) seq_step = SEQ_RST_WAIT;
         end
         SEQ_RST_WAIT: begin
            if (duration_over(bus_timing[CSR_PRESENCE_WAIT])) begin
               presence_q = line_in;
               seq_step   = SEQ_RST_TAIL;
            end
         end
         SEQ_RST_TAIL: begin
            // A missing presence pulse is only reported; the sequence goes on.
            if (duration_over(bus_timing[CSR_RESET_TAIL])) begin
               status_q = presence_q ? STAT_ABSENT : STAT_PRESENT;
               open_commands();
            end
         end
         SEQ_WR_START: begin
            if (duration_over(bus_timing[CSR_SLOT_START])) seq_step = SEQ_WR_HOLD;
         end
         SEQ_WR_HOLD: begin
            if (duration_over(bus_timing[CSR_WRITE_SLOT])) begin
               shift_reg = shift_reg >> 1;
               bit_cnt   = bit_cnt + 3'd1;
               seq_step  = SEQ_WR_START;
               if (bit_cnt == 3'd0) begin
                  byte_cnt = byte_cnt + 4'd1;
                  if (byte_cnt >= 4'd2) begin
                     byte_cnt = '0;
                     seq_step = second_round ? SEQ_RD_START : SEQ_CONVERT;
                  end else begin
                     shift_reg = second_round ? CMD_READ_SCRATCH : CMD_CONVERT;
                  end
               end
            end
         end
         SEQ_CONVERT: begin
            if (duration_over(bus_timing[CSR_CONV_WAIT])) begin
               second_round = 1'b1;
               seq_step     = SEQ_CHECK;
            end
         end
         SEQ_RD_START: begin
            if (duration_over(bus_timing[CSR_SLOT_START])) seq_step = SEQ_RD_WAIT;
         end
         SEQ_RD_WAIT: begin
            if (duration_over(bus_timing[CSR_READ_SAMPLE])) begin
               shift_reg = {line_in, shift_reg[7:1]};
               seq_step  = SEQ_RD_TAIL;
            end
         end
         SEQ_RD_TAIL: begin
            if (duration_over(bus_timing[CSR_READ_TAIL])) begin
               bit_cnt  = bit_cnt + 3'd1;
               seq_step = SEQ_RD_START;
               if (bit_cnt == 3'd0) begin
                  // The first two scratchpad bytes are the raw reading, low
                  // byte first; the rest are clocked in and dropped.
                  if (byte_cnt == 4'd0) raw_temp[7:0] = shift_reg;
                  else if (byte_cnt == 4'd1) raw_temp[15:8] = shift_reg;
                  byte_cnt = byte_cnt + 4'd1;
                  if (byte_cnt >= 4'(SCRATCH_BYTES)) begin
                     degrees  = 11'(raw_temp[10:4]) * 11'd10;
                     fraction = (8'(raw_temp[3:0]) * 8'd10) >> 4;
                     tenths_q = degrees + 11'(fraction);
                     word.done_res = 1'b1;
                     byte_cnt      = '0;
                     seq_step      = SEQ_IDLE;
                     second_round  = 1'b0;
                  end
               end
            end
         end
         default: begin
            seq_step = SEQ_IDLE;
            tick_cnt = '0;
         end
      endcase
      word.status             = status_q;
      word.temperature_tenths = tenths_q;
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Sends one tick word after an optional gap. On acceptance the copy is
   // stepped, and the typed word or the predicted one is queued.
   task automatic send_tick(input logic start_req, input logic line_in,
                            input logic known, input rsp_word_type want);
      int unsigned  gap;
      rsp_word_type predicted;
      gap = (no_idling || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, line_in, start_req};
      do @(posedge clock); while (!req_tready);
      predicted = step_bus_master(start_req, line_in);
      predicted_words.push_back(known ? want : predicted);
   endtask

   // Random tick shaped to get deep into the sequence: the line check mostly
   // sees a released bus and presence is mostly pulled low, while read bits
   // are free. Starts come often while idle and at random while busy.
   task automatic send_random_tick();
      logic start_req;
      logic line_in;
      case (seq_step)
         SEQ_CHECK:    line_in = ($urandom_range(0, 9) != 0);
         SEQ_RST_WAIT: line_in = ($urandom_range(0, 4) == 0);
         default:      line_in = 1'($urandom_range(0, 1));
      endcase
      start_req = (seq_step == SEQ_IDLE) ? ($urandom_range(0, 2) == 0)
                                         : 1'($urandom_range(0, 1));
      send_tick(start_req, line_in, 1'b0, IDLE_WORD);
   endtask

   // One register write. The copy takes the value with the register's width;
   // the junk above bit 15 on the short registers must be dropped.
   task automatic write_timing(input logic [2:0] code, input logic [DUR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= code;
      csr_wdata <= value;
      bus_timing[code] = (code == CSR_CONV_WAIT) ? value : {4'b0, value[15:0]};
   endtask

   task automatic program_timing(input timing_mode_type mode);
      int               n;
      logic [DUR_W-1:0] value;
      for (n = 0; n < 8; n++) begin
         case (mode)
            TIMING_ONES:  value = 20'd1;
            TIMING_ZEROS: value = '0;
            TIMING_MAX:   value = '1;
            default:      value = 20'($urandom_range(1, 2));
         endcase
         if (REG_ORDER[n] != CSR_CONV_WAIT && mode != TIMING_MAX)
            value[19:16] = 4'($urandom_range(0, 15));
         write_timing(REG_ORDER[n], value);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drops valid and waits until every owed word has come back, so the registers
   // can be rewritten.
   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic run_phase(input timing_mode_type mode, input int ticks, input logic calm);
      no_idling <= calm;
      program_timing(mode);
      repeat (ticks) send_random_tick();
      drain_words();
   endtask

   initial begin : stimulus
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      reset_bus_master();

      for (n = 0; n < $size(OPENING_TICKS); n++)
         send_tick(OPENING_TICKS[n].start_req, OPENING_TICKS[n].line_in,
                   OPENING_TICKS[n].known, OPENING_TICKS[n].want);
      drain_words();

      // The sequence carries over each reprogramming, so a long count left
      // from one phase meets a short duration in the next.
      run_phase(TIMING_ONES, 400, 1'b0);
      run_phase(TIMING_ZEROS, 300, 1'b1);
      run_phase(TIMING_SHORT_RANDOM, 500, 1'b0);
      run_phase(TIMING_MAX, 150, 1'b0);
      run_phase(TIMING_SHORT_RANDOM, 500, 1'b0);

      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("one_wire_temperature_reader_test OK");
      else
         $display("one_wire_temperature_reader_test NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Receiver stalls: runs of ready low of random length, none while the
   // phase asks for a clean stretch.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 6'd1;
         rsp_tready <= 1'b0;
      end else if (!reset && !no_idling && $urandom_range(0, 4) == 0) begin
         stall_left <= 6'(pick_gap() - 1);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata[16:0]);
         if (predicted_words.size() == 0) begin
            $error("response word 0x%h arrived with nothing owed", rsp_tdata);
            mismatch_count++;
         end else begin
            want = predicted_words.pop_front();
            check_field("drive_low", want.drive_low, got.drive_low);
            check_field("power_on", want.power_on, got.power_on);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("status", want.status, got.status);
            check_field("temperature_tenths", want.temperature_tenths,
                        got.temperature_tenths);
         end
      end
   end

endmodule

// ----- one_wire_temperature_reader.f -----
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_tick_timer.sv
hw/rtl/owtr_sequencer.sv
hw/rtl/one_wire_temperature_reader.sv
tb/one_wire_temperature_reader_test.sv
